@@ design/nodata_neighbor_fill_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the nodata neighbor fill block
// Reset-gated implication checks shared by the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef NODATA_NEIGHBOR_FILL_TOP_ASSERT_SVH
`define NODATA_NEIGHBOR_FILL_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NNF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NNF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/nnf_pkg.sv @@
// ----------------------------------------------------------------------------
// nnf_pkg
// Shared constants, types and helpers for the nodata neighbor fill block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nnf_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int SAMPLE_BITS = 32;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int NCOL_W      = 11;              // num_cols register
    localparam int NROW_W      = 16;              // num_rows register
    localparam int SUM_W       = SAMPLE_BITS + 2; // sum of four samples
    localparam int CNT_W       = 3;               // neighbor count 0..4
    localparam int REM_W       = 2;               // remainder below count
    localparam int DIV_BITS    = 2;               // quotient bits per cycle
    localparam int DIV_STEPS   = (SUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W       = DIV_STEPS * DIV_BITS;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int REG_IDX_W   = 2;
    localparam int CFG_W       = SAMPLE_BITS;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_NODATA   = 2'd0;
    localparam t_reg_idx REG_NUM_COLS = 2'd1;
    localparam t_reg_idx REG_NUM_ROWS = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam logic signed [SAMPLE_BITS-1:0] NODATA_RESET = -32'sd409596000;
    localparam logic [NCOL_W-1:0] NUM_COLS_RESET = 11'd1024;
    localparam logic [NROW_W-1:0] NUM_ROWS_RESET = 16'd1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [COL_W-1:0]              t_col;

    // controller -> datapath
    typedef struct packed {
        logic  take;        // beat accepted and acted on
        t_col  rd_addr;
        t_col  wr_addr;
        logic  wr_en;
        logic  cap_center;  // store read of column c is on the RAM outputs
        logic  cap_east;    // store read of column c+1 is on the RAM outputs
        logic  calc;
        logic  div_step;
        logic  out_load;
        logic  drain;
        logic  in_n;
        logic  in_e;
        logic  in_w;
        logic  frame_end;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_stat;

    function automatic logic [COL_W:0] eff_cols(input logic [NCOL_W-1:0] n);
        if (n == '0) return (COL_W + 1)'(1);
        if (32'(n) > MAX_COLS) return (COL_W + 1)'(MAX_COLS);
        return (COL_W + 1)'(n);
    endfunction

    function automatic logic [NROW_W-1:0] eff_rows(input logic [NROW_W-1:0] n);
        return (n == '0) ? NROW_W'(1) : n;
    endfunction

endpackage

`default_nettype wire

@@ design/nnf_if.sv @@
// ----------------------------------------------------------------------------
// nnf channel interfaces
// Input sample, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nnf_in_if import nnf_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    op;
    t_sample elevation;
    modport source (output valid, output op, output elevation, input ready);
    modport sink   (input valid, input op, input elevation, output ready);
endinterface

interface nnf_out_if import nnf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample corrected_elevation;
    logic    weir_flag;
    logic    frame_end;
    modport source (output valid, output corrected_elevation, output weir_flag,
                    output frame_end, input ready);
    modport sink   (input valid, input corrected_elevation, input weir_flag,
                    input frame_end, output ready);
endinterface

interface nnf_cfg_if import nnf_pkg::*; ();
    logic             valid;
    logic             ready;
    t_reg_idx         index;
    logic [CFG_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/nnf_ram.sv @@
// ----------------------------------------------------------------------------
// nnf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nnf_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ design/nnf_ctrl.sv @@
// ----------------------------------------------------------------------------
// nnf_ctrl
// Raster position counters and per-beat sequencer for the fill datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "nodata_neighbor_fill_top_assert.svh"

module nnf_ctrl import nnf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_op,
    input  wire logic [NCOL_W-1:0] i_num_cols,
    input  wire logic [NROW_W-1:0] i_num_rows,
    input  wire t_stat             i_stat,
    output logic                   o_in_ready,
    output t_cmd                   o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_C,
        ST_RD_E,
        ST_WR,
        ST_CALC,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state              r_state;
    t_col                r_col;
    t_col                r_input_col;
    logic [NROW_W-1:0]   r_input_row;
    t_col                r_drain_col;
    logic                r_drain;
    logic                r_emit;
    logic                r_in_n;
    logic                r_in_e;
    logic                r_in_w;
    logic                r_frame_end;
    logic [STEP_W-1:0]   r_step;

    logic [COL_W:0]      nc;
    logic [NROW_W-1:0]   nr;
    logic                in_phase;
    logic                act;
    logic                take;
    t_col                col;
    logic [COL_W:0]      col_next;
    logic                last;

    always_comb begin
        nc       = eff_cols(i_num_cols);
        nr       = eff_rows(i_num_rows);
        in_phase = r_input_row < nr;
        act      = in_phase ? (i_in_op == OP_SAMPLE) : (i_in_op == OP_DRAIN);
        take     = (r_state == ST_IDLE) && i_in_valid && act;
        col      = in_phase ? r_input_col : r_drain_col;
        col_next = {1'b0, col} + (COL_W + 1)'(1);
        last     = col_next >= nc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_input_col <= '0;
            r_input_row <= '0;
            r_drain_col <= '0;
            r_step      <= '0;
            r_col       <= '0;
            r_drain     <= 1'b0;
            r_emit      <= 1'b0;
            r_in_n      <= 1'b0;
            r_in_e      <= 1'b0;
            r_in_w      <= 1'b0;
            r_frame_end <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        r_col       <= col;
                        r_drain     <= !in_phase;
                        r_emit      <= !in_phase || (r_input_row != '0);
                        r_in_n      <= in_phase ? (r_input_row > NROW_W'(1))
                                                : (nr > NROW_W'(1));
                        r_in_e      <= !last;
                        r_in_w      <= col != '0;
                        r_frame_end <= !in_phase && last;
                        if (in_phase) begin
                            if (last) begin
                                r_input_col <= '0;
                                r_input_row <= r_input_row + NROW_W'(1);
                            end else begin
                                r_input_col <= col_next[COL_W-1:0];
                            end
                        end else begin
                            if (last) begin
                                r_input_col <= '0;
                                r_input_row <= '0;
                                r_drain_col <= '0;
                            end else begin
                                r_drain_col <= col_next[COL_W-1:0];
                            end
                        end
                        r_state <= ST_RD_C;
                    end
                end
                ST_RD_C: begin
                    r_state <= ST_RD_E;
                end
                ST_RD_E: begin
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    r_state <= r_emit ? ST_CALC : ST_IDLE;
                end
                ST_CALC: begin
                    r_step  <= '0;
                    r_state <= i_stat.need_div ? ST_DIV : ST_OUT;
                end
                ST_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_LAST) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_stat.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_in_ready       = r_state == ST_IDLE;
        o_cmd.take       = take;
        o_cmd.rd_addr    = (r_state == ST_RD_E) ? (r_col + COL_W'(1)) : r_col;
        o_cmd.wr_addr    = r_col;
        o_cmd.wr_en      = (r_state == ST_WR) && !r_drain;
        o_cmd.cap_center = r_state == ST_RD_E;
        o_cmd.cap_east   = r_state == ST_WR;
        o_cmd.calc       = r_state == ST_CALC;
        o_cmd.div_step   = r_state == ST_DIV;
        o_cmd.out_load   = (r_state == ST_OUT) && i_stat.out_free;
        o_cmd.drain      = r_drain;
        o_cmd.in_n       = r_in_n;
        o_cmd.in_e       = r_in_e;
        o_cmd.in_w       = r_in_w;
        o_cmd.frame_end  = r_frame_end;
    end

    `NNF_ASSERT_SAME(a_no_store_write_in_drain, i_clk, i_rst_n, o_cmd.wr_en, !r_drain, "row store written during drain")
    `NNF_ASSERT_NEXT(a_div_ends_in_out, i_clk, i_rst_n, (r_state == ST_DIV) && (r_step == STEP_LAST), r_state == ST_OUT, "divider overran its step count")

endmodule

`default_nettype wire

@@ design/nnf_dp.sv @@
// ----------------------------------------------------------------------------
// nnf_dp
// Row stores, neighbor registers, masked sum, serial divider, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "nodata_neighbor_fill_top_assert.svh"

module nnf_dp import nnf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_cmd,
    input  wire t_sample i_elevation,
    input  wire t_sample i_nodata,
    input  wire logic    i_out_ready,
    output t_stat        o_stat,
    output logic         o_out_valid,
    output t_sample      o_corrected_elevation,
    output logic         o_weir_flag,
    output logic         o_frame_end
);

    localparam t_sample SMIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    localparam t_sample SMAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

    t_sample            older_q;
    t_sample            newer_q;

    t_sample            r_sample;
    t_sample            r_center;
    t_sample            r_west;
    t_sample            r_north;
    t_sample            r_east;
    logic               r_neg;
    logic               r_sum_zero;
    logic               r_weir;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_W-1:0]   r_quot;
    logic [REM_W-1:0]   r_rem;
    logic               r_out_valid;
    t_sample            r_out_elev;
    logic               r_out_weir;
    logic               r_out_fend;

    t_sample                  nb [4];
    logic [3:0]               in_grid;
    logic [3:0]               pick;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]         mag;
    logic [CNT_W-1:0]         cnt;
    logic                     center_weir;
    logic [DIV_W-1:0]         quot_nx;
    logic [REM_W-1:0]         rem_nx;
    logic [CNT_W-1:0]         trial;
    logic [DIV_W-1:0]         mean_w;
    t_sample                  abs_v;
    t_sample                  result;

    nnf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLS)) u_older (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_cmd.wr_addr),
        .i_wr_data (r_center),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (older_q)
    );

    nnf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLS)) u_newer (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_cmd.wr_addr),
        .i_wr_data (r_sample),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (newer_q)
    );

    // masked neighbor sum: south, north, east, west
    always_comb begin
        nb[0]      = r_sample;
        nb[1]      = r_north;
        nb[2]      = r_east;
        nb[3]      = r_west;
        in_grid[0] = !i_cmd.drain;
        in_grid[1] = i_cmd.in_n;
        in_grid[2] = i_cmd.in_e;
        in_grid[3] = i_cmd.in_w;
        sum        = '0;
        cnt        = '0;
        for (int i = 0; i < 4; i++) begin
            pick[i] = in_grid[i] && (nb[i] != i_nodata) && (nb[i] != '0);
            if (pick[i]) begin
                sum = sum + SUM_W'(nb[i]);
                cnt = cnt + CNT_W'(1);
            end
        end
        mag         = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        center_weir = (r_center == i_nodata) || (r_center == '0);
    end

    // restoring divide of the magnitude by the count, DIV_BITS per cycle
    always_comb begin
        quot_nx = r_quot;
        rem_nx  = r_rem;
        trial   = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial   = {rem_nx, quot_nx[DIV_W-1]};
            quot_nx = {quot_nx[DIV_W-2:0], 1'b0};
            if (trial >= r_cnt) begin
                trial      = trial - r_cnt;
                quot_nx[0] = 1'b1;
            end
            rem_nx = trial[REM_W-1:0];
        end
    end

    always_comb begin
        mean_w = r_neg ? (~r_quot + DIV_W'(1)) : r_quot;
        if (r_center[SAMPLE_BITS-1]) begin
            abs_v = (r_center == SMIN) ? SMAX : -r_center;
        end else begin
            abs_v = r_center;
        end
        if (!r_weir) begin
            result = abs_v;
        end else if (r_sum_zero) begin
            result = r_center;
        end else begin
            result = mean_w[SAMPLE_BITS-1:0];
        end
        o_stat.need_div = center_weir && (sum != '0);
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_elevation;
        end
        if (i_cmd.cap_center) begin
            r_west   <= r_center;
            r_center <= newer_q;
            r_north  <= older_q;
        end
        if (i_cmd.cap_east) begin
            r_east <= newer_q;
        end
        if (i_cmd.calc) begin
            r_neg      <= sum[SUM_W-1];
            r_sum_zero <= sum == '0;
            r_weir     <= center_weir;
            r_cnt      <= cnt;
            r_quot     <= DIV_W'(mag);
            r_rem      <= '0;
        end else if (i_cmd.div_step) begin
            r_quot <= quot_nx;
            r_rem  <= rem_nx;
        end
        if (i_cmd.out_load) begin
            r_out_elev <= result;
            r_out_weir <= r_weir;
            r_out_fend <= i_cmd.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_corrected_elevation = r_out_elev;
    assign o_weir_flag           = r_out_weir;
    assign o_frame_end           = r_out_fend;

    `NNF_ASSERT_SAME(a_rem_below_count, i_clk, i_rst_n, i_cmd.div_step, {1'b0, r_rem} < r_cnt, "divider remainder not below divisor")
    `NNF_ASSERT_SAME(a_load_into_free_slot, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || i_out_ready, "result overwritten before taken")

endmodule

`default_nettype wire

@@ design/nodata_neighbor_fill_top.sv @@
// ----------------------------------------------------------------------------
// nodata_neighbor_fill_top
// Raster nodata fill: four-neighbor mean of valid cells, one row behind input.
// ----------------------------------------------------------------------------
//
//  channel  dir   handshake      beat contents
//  -------  ----  -------------  ----------------------------------------------
//  i_in     in    valid/ready    op (0 sample, 1 drain), elevation Q20.12
//  o_out    out   valid/ready    corrected_elevation, weir_flag, frame_end
//  i_cfg    in    valid/ready    index (0 nodata, 1 num_cols, 2 num_rows), data
//
//  Steps: an ignored beat is taken and dropped; a first-row sample is accepted,
//  then makes two store reads through the single read port and a store write;
//  a cell with a result adds the calc and output steps; a filled weir cell with
//  nonzero neighbor sum adds the 2-bit-per-cycle divide by the neighbor count.
//  Reset: synchronous, active low; loads the register defaults and clears
//  counters, sequencer and result valid. Row stores are not cleared and
//  need no clearing pass.
//  Stalls: a finished result sits in the output register; the next beat is
//  accepted and worked on, and waits only when its own result is ready.
//  i_cfg is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nodata_neighbor_fill_top import nnf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nnf_in_if.sink     i_in,
    nnf_out_if.source  o_out,
    nnf_cfg_if.sink    i_cfg
);

    // configuration registers
    t_sample           r_nodata;
    logic [NCOL_W-1:0] r_num_cols;
    logic [NROW_W-1:0] r_num_rows;

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodata   <= NODATA_RESET;
            r_num_cols <= NUM_COLS_RESET;
            r_num_rows <= NUM_ROWS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_NODATA:   r_nodata   <= i_cfg.data[SAMPLE_BITS-1:0];
                REG_NUM_COLS: r_num_cols <= i_cfg.data[NCOL_W-1:0];
                REG_NUM_ROWS: r_num_rows <= i_cfg.data[NROW_W-1:0];
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // sequencer: raster counters, store read/write order, divide steps
    nnf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .i_num_cols (r_num_cols),
        .i_num_rows (r_num_rows),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // datapath: two line stores, neighbor window, sum, divider, result reg
    nnf_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_elevation           (i_in.elevation),
        .i_nodata              (r_nodata),
        .i_out_ready           (o_out.ready),
        .o_stat                (stat),
        .o_out_valid           (o_out.valid),
        .o_corrected_elevation (o_out.corrected_elevation),
        .o_weir_flag           (o_out.weir_flag),
        .o_frame_end           (o_out.frame_end)
    );

endmodule

`default_nettype wire
